/* rtl/cau_pkg.sv */
`timescale 1ns / 1ps

package cau_pkg;

    // Fixed field widths of the ports.
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int TOL_W    = 31;

    // Defaults for the top-level parameters.
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam logic [TOL_W-1:0] TOL_RESET = 31'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_NEG = 3'd4,
        MODE_EQ  = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    // One finished result item.
    typedef struct packed {
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic              eq;
        status_t           status;
    } result_t;

endpackage

/* rtl/complex_arithmetic_unit_top.sv */
`timescale 1ns / 1ps

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+---------------------------------------
// s_       | in        | s_valid / s_ready  | s_mode, s_a_re, s_a_im, s_b_re, s_b_im
// m_       | out       | m_valid / m_ready  | m_res_re, m_res_im, m_is_equal, m_status
// cfg_     | in        | cfg_we (no wait)   | cfg_wdata (equality tolerance)
//
// One item can be accepted in every cycle while the pipeline has room. Each item passes
// DATA_W + 6 register stages, all modes alike; the restoring divider, one quotient bit per
// stage, sets this depth. Reset is synchronous and active low; it empties the pipeline
// and sets the tolerance to 1. Each stage holds its item only while the stage after it is
// full and stalled, so any empty stage still lets a new item in while the output waits.

module complex_arithmetic_unit_top #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [cau_pkg::MODE_W-1:0]          s_mode,
    input  logic signed [cau_pkg::DATA_W-1:0]   s_a_re,
    input  logic signed [cau_pkg::DATA_W-1:0]   s_a_im,
    input  logic signed [cau_pkg::DATA_W-1:0]   s_b_re,
    input  logic signed [cau_pkg::DATA_W-1:0]   s_b_im,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [cau_pkg::DATA_W-1:0]   m_res_re,
    output logic signed [cau_pkg::DATA_W-1:0]   m_res_im,
    output logic                                m_is_equal,
    output logic [cau_pkg::STATUS_W-1:0]        m_status,
    input  logic                                cfg_we,
    input  logic [cau_pkg::TOL_W-1:0]           cfg_wdata
);
    import cau_pkg::*;

    // Results saturate to the narrower of the word and the port width.
    localparam int SAT_BITS = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int SW       = SUM_W + 1;
    localparam int MAG_W    = SUM_W + FRAC_BITS;
    localparam int Q_W      = DATA_W;
    localparam int DEN_W    = PROD_W;
    localparam int RW       = (MAG_W > DEN_W + Q_W) ? MAG_W : DEN_W + Q_W;
    localparam int NST      = Q_W + 6;
    localparam int DV0      = 4;
    localparam int OUT_ST   = NST - 1;

    localparam logic signed [SW-1:0] SAT_MAX =
        {{(SW - SAT_BITS + 1){1'b0}}, {(SAT_BITS - 1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;

    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] val;
    } sat_t;

    // One divider stage: remainders and quotient bits for both components.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        result_t           res;
        logic [RW-1:0]     rem_re;
        logic [RW-1:0]     rem_im;
        logic [Q_W-1:0]    q_re;
        logic [Q_W-1:0]    q_im;
        logic              neg_re;
        logic              neg_im;
        logic              ovf_re;
        logic              ovf_im;
        logic [DEN_W-1:0]  den;
        logic              zero;
    } div_st_t;

    function automatic sat_t sat_word(input logic signed [SW-1:0] v);
        sat_t r;
        if (v > SAT_MAX) begin
            r.sat = 1'b1;
            r.val = SAT_MAX[DATA_W-1:0];
        end else if (v < SAT_MIN) begin
            r.sat = 1'b1;
            r.val = SAT_MIN[DATA_W-1:0];
        end else begin
            r.sat = 1'b0;
            r.val = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // Signed quotient from its magnitude; an overflowed magnitude always saturates.
    function automatic sat_t div_sat(input logic neg, input logic [Q_W-1:0] q,
                                     input logic ovf);
        sat_t                  r;
        logic signed [SW-1:0]  v;
        v = $signed(SW'({1'b0, q}));
        if (ovf) begin
            r.sat = 1'b1;
            r.val = neg ? SAT_MIN[DATA_W-1:0] : SAT_MAX[DATA_W-1:0];
        end else begin
            r = sat_word(neg ? -v : v);
        end
        return r;
    endfunction

    // Configuration register.
    logic [TOL_W-1:0] tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (cfg_we) begin
            tol_reg <= cfg_wdata;
        end
    end

    // Valid bits and per-stage load enables. A stage loads when it is empty or
    // when the stage after it loads in the same cycle.
    logic [NST-1:0] v_reg;
    logic [NST-1:0] ld;

    always_comb begin
        ld[OUT_ST] = !v_reg[OUT_ST] || m_ready;
        for (int k = OUT_ST - 1; k >= 0; k--) begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    assign s_ready = ld[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (ld[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Stage 0: input register.
    logic [MODE_W-1:0]        s0_mode_reg;
    logic signed [DATA_W-1:0] s0_ar_reg, s0_ai_reg, s0_br_reg, s0_bi_reg;

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            s0_mode_reg <= s_mode;
            s0_ar_reg   <= s_a_re;
            s0_ai_reg   <= s_a_im;
            s0_br_reg   <= s_b_re;
            s0_bi_reg   <= s_b_im;
        end
    end

    // Stage 1: six products, and the result of the modes that need no product.
    logic signed [PROD_W-1:0] p1_next, p2_next, p3_next, p4_next, p5_next, p6_next;
    logic signed [PROD_W-1:0] s1_p1_reg, s1_p2_reg, s1_p3_reg, s1_p4_reg, s1_p5_reg,
                              s1_p6_reg;
    logic [MODE_W-1:0]        s1_mode_reg;
    result_t                  s1_res_next, s1_res_reg;
    sat_t                     sr_re, sr_im;
    logic signed [DATA_W:0]   dif_re, dif_im;
    logic [DATA_W:0]          adif_re, adif_im;

    assign p1_next = s0_ar_reg * s0_br_reg;
    assign p2_next = s0_ai_reg * s0_bi_reg;
    assign p3_next = s0_ar_reg * s0_bi_reg;
    assign p4_next = s0_ai_reg * s0_br_reg;
    assign p5_next = s0_br_reg * s0_br_reg;
    assign p6_next = s0_bi_reg * s0_bi_reg;

    always_comb begin
        dif_re  = (DATA_W + 1)'(s0_ar_reg) - (DATA_W + 1)'(s0_br_reg);
        dif_im  = (DATA_W + 1)'(s0_ai_reg) - (DATA_W + 1)'(s0_bi_reg);
        adif_re = dif_re[DATA_W] ? (DATA_W + 1)'(-dif_re) : (DATA_W + 1)'(dif_re);
        adif_im = dif_im[DATA_W] ? (DATA_W + 1)'(-dif_im) : (DATA_W + 1)'(dif_im);
        sr_re   = '0;
        sr_im   = '0;
        s1_res_next = '0;
        unique case (s0_mode_reg)
            MODE_ADD: begin
                sr_re = sat_word(SW'(s0_ar_reg) + SW'(s0_br_reg));
                sr_im = sat_word(SW'(s0_ai_reg) + SW'(s0_bi_reg));
            end
            MODE_SUB: begin
                sr_re = sat_word(SW'(s0_ar_reg) - SW'(s0_br_reg));
                sr_im = sat_word(SW'(s0_ai_reg) - SW'(s0_bi_reg));
            end
            MODE_NEG: begin
                sr_re = sat_word(-SW'(s0_ar_reg));
                sr_im = sat_word(-SW'(s0_ai_reg));
            end
            MODE_EQ: begin
                s1_res_next.eq = (adif_re < (DATA_W + 1)'(tol_reg))
                              && (adif_im < (DATA_W + 1)'(tol_reg));
            end
            default: begin
                sr_re = '0;
                sr_im = '0;
            end
        endcase
        s1_res_next.re     = sr_re.val;
        s1_res_next.im     = sr_im.val;
        s1_res_next.status = (sr_re.sat || sr_im.sat) ? ST_SAT : ST_OK;
    end

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            s1_mode_reg <= s0_mode_reg;
            s1_res_reg  <= s1_res_next;
            s1_p1_reg   <= p1_next;
            s1_p2_reg   <= p2_next;
            s1_p3_reg   <= p3_next;
            s1_p4_reg   <= p4_next;
            s1_p5_reg   <= p5_next;
            s1_p6_reg   <= p6_next;
        end
    end

    // Stage 2: product sums; the multiply result is finished here.
    logic signed [SUM_W-1:0] mul_re, mul_im;
    logic signed [SUM_W-1:0] s2_dre_reg, s2_dim_reg;
    logic [DEN_W-1:0]        s2_den_reg;
    logic [MODE_W-1:0]       s2_mode_reg;
    result_t                 s2_res_next, s2_res_reg;
    sat_t                    sm_re, sm_im;

    always_comb begin
        mul_re = SUM_W'(s1_p1_reg) - SUM_W'(s1_p2_reg);
        mul_im = SUM_W'(s1_p3_reg) + SUM_W'(s1_p4_reg);
        sm_re  = sat_word(SW'(mul_re >>> FRAC_BITS));
        sm_im  = sat_word(SW'(mul_im >>> FRAC_BITS));
        s2_res_next = s1_res_reg;
        if (s1_mode_reg == MODE_MUL) begin
            s2_res_next.re     = sm_re.val;
            s2_res_next.im     = sm_im.val;
            s2_res_next.status = (sm_re.sat || sm_im.sat) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            s2_mode_reg <= s1_mode_reg;
            s2_res_reg  <= s2_res_next;
            s2_dre_reg  <= SUM_W'(s1_p1_reg) + SUM_W'(s1_p2_reg);
            s2_dim_reg  <= SUM_W'(s1_p4_reg) - SUM_W'(s1_p3_reg);
            s2_den_reg  <= DEN_W'(s1_p5_reg) + DEN_W'(s1_p6_reg);
        end
    end

    // Stage 3: sign and scaled magnitude of the divide numerators.
    logic [SUM_W-1:0]  abs_re, abs_im;
    logic [MAG_W-1:0]  s3_mre_reg, s3_mim_reg;
    logic              s3_nre_reg, s3_nim_reg, s3_zero_reg;
    logic [DEN_W-1:0]  s3_den_reg;
    logic [MODE_W-1:0] s3_mode_reg;
    result_t           s3_res_reg;

    assign abs_re = s2_dre_reg[SUM_W-1] ? SUM_W'(-s2_dre_reg) : SUM_W'(s2_dre_reg);
    assign abs_im = s2_dim_reg[SUM_W-1] ? SUM_W'(-s2_dim_reg) : SUM_W'(s2_dim_reg);

    always_ff @(posedge aclk) begin
        if (ld[3]) begin
            s3_mode_reg <= s2_mode_reg;
            s3_res_reg  <= s2_res_reg;
            s3_mre_reg  <= MAG_W'(abs_re) << FRAC_BITS;
            s3_mim_reg  <= MAG_W'(abs_im) << FRAC_BITS;
            s3_nre_reg  <= s2_dre_reg[SUM_W-1];
            s3_nim_reg  <= s2_dim_reg[SUM_W-1];
            s3_den_reg  <= s2_den_reg;
            s3_zero_reg <= (s2_den_reg == '0);
        end
    end

    // Divider: entry stage flags quotients too large for the word, then one
    // quotient bit per stage, most significant first.
    div_st_t dv_reg [Q_W+1];
    div_st_t dv0_next;

    always_comb begin
        dv0_next        = '0;
        dv0_next.mode   = s3_mode_reg;
        dv0_next.res    = s3_res_reg;
        dv0_next.rem_re = RW'(s3_mre_reg);
        dv0_next.rem_im = RW'(s3_mim_reg);
        dv0_next.neg_re = s3_nre_reg;
        dv0_next.neg_im = s3_nim_reg;
        dv0_next.ovf_re = RW'(s3_mre_reg) >= (RW'(s3_den_reg) << Q_W);
        dv0_next.ovf_im = RW'(s3_mim_reg) >= (RW'(s3_den_reg) << Q_W);
        dv0_next.den    = s3_den_reg;
        dv0_next.zero   = s3_zero_reg;
    end

    always_ff @(posedge aclk) begin
        if (ld[DV0]) begin
            dv_reg[0] <= dv0_next;
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_div
        localparam int BIT = Q_W - k;
        div_st_t       dv_next;
        logic [RW-1:0] dsh;
        logic          ge_re, ge_im;

        always_comb begin
            dsh     = RW'(dv_reg[k-1].den) << BIT;
            ge_re   = dv_reg[k-1].rem_re >= dsh;
            ge_im   = dv_reg[k-1].rem_im >= dsh;
            dv_next = dv_reg[k-1];
            dv_next.rem_re = ge_re ? dv_reg[k-1].rem_re - dsh : dv_reg[k-1].rem_re;
            dv_next.rem_im = ge_im ? dv_reg[k-1].rem_im - dsh : dv_reg[k-1].rem_im;
            dv_next.q_re[BIT] = ge_re;
            dv_next.q_im[BIT] = ge_im;
        end

        always_ff @(posedge aclk) begin
            if (ld[DV0+k]) begin
                dv_reg[k] <= dv_next;
            end
        end
    end

    // Output stage: signed, saturated quotient for divide, carried result otherwise.
    result_t out_next, out_reg;
    sat_t    sd_re, sd_im;

    always_comb begin
        sd_re    = div_sat(dv_reg[Q_W].neg_re, dv_reg[Q_W].q_re, dv_reg[Q_W].ovf_re);
        sd_im    = div_sat(dv_reg[Q_W].neg_im, dv_reg[Q_W].q_im, dv_reg[Q_W].ovf_im);
        out_next = dv_reg[Q_W].res;
        if (dv_reg[Q_W].mode == MODE_DIV) begin
            if (dv_reg[Q_W].zero) begin
                out_next        = '0;
                out_next.status = ST_DIV0;
            end else begin
                out_next.re     = sd_re.val;
                out_next.im     = sd_im.val;
                out_next.eq     = 1'b0;
                out_next.status = (sd_re.sat || sd_im.sat) ? ST_SAT : ST_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[OUT_ST]) begin
            out_reg <= out_next;
        end
    end

    assign m_valid    = v_reg[OUT_ST];
    assign m_res_re   = out_reg.re;
    assign m_res_im   = out_reg.im;
    assign m_is_equal = out_reg.eq;
    assign m_status   = out_reg.status;

`ifndef SYNTHESIS
    // Input is refused only when every stage is full and the output is stalled.
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&v_reg && !m_ready))
        else $error("input refused while the pipeline has room");

    // Items in flight change only by items accepted and delivered.
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> $countones(v_reg) == $past($countones(v_reg))
            + ($past(s_valid && s_ready) ? 1 : 0) - ($past(m_valid && m_ready) ? 1 : 0))
        else $error("pipeline lost or duplicated an item");

    // Division by zero delivers a zero result.
    a_div0_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_DIV0) |-> (m_res_re == '0 && m_res_im == '0
            && !m_is_equal))
        else $error("division by zero result not cleared");

    // An equality hit carries no arithmetic result and no error.
    a_eq_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_equal) |-> (m_status == ST_OK && m_res_re == '0
            && m_res_im == '0))
        else $error("equality result mixed with arithmetic result");
`endif

endmodule

/* tb/complex_arithmetic_unit_checker.sv */
`timescale 1ns / 1ps

module complex_arithmetic_unit_checker #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [cau_pkg::MODE_W-1:0]        s_mode,
    input  logic signed [cau_pkg::DATA_W-1:0] s_a_re,
    input  logic signed [cau_pkg::DATA_W-1:0] s_a_im,
    input  logic signed [cau_pkg::DATA_W-1:0] s_b_re,
    input  logic signed [cau_pkg::DATA_W-1:0] s_b_im,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [cau_pkg::DATA_W-1:0] m_res_re,
    input  logic signed [cau_pkg::DATA_W-1:0] m_res_im,
    input  logic                              m_is_equal,
    input  logic [cau_pkg::STATUS_W-1:0]      m_status,
    input  logic                              cfg_we,
    input  logic [cau_pkg::TOL_W-1:0]         cfg_wdata,
    output int                                mismatches,
    output int                                pending
);
    import cau_pkg::*;

    typedef logic signed [127:0] wide_t;

    localparam wide_t WORD_MAX = 128'sd2147483647;
    localparam wide_t WORD_MIN = -128'sd2147483648;

    logic [TOL_W-1:0] tolerance;
    result_t          awaited_q[$];

    // Clamps a wide value to the signed 32-bit range and flags the clamp.
    function automatic logic [DATA_W-1:0] clamp_word(input wide_t v, inout bit clipped);
        if (v > WORD_MAX) begin
            clipped = 1'b1;
            return WORD_MAX[DATA_W-1:0];
        end
        if (v < WORD_MIN) begin
            clipped = 1'b1;
            return WORD_MIN[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic result_t complex_result(
        input logic [MODE_W-1:0]        op,
        input logic signed [DATA_W-1:0] ar,
        input logic signed [DATA_W-1:0] ai,
        input logic signed [DATA_W-1:0] br,
        input logic signed [DATA_W-1:0] bi,
        input logic [TOL_W-1:0]         tol
    );
        wide_t   xr, xi, yr, yi, part_re, part_im, mag2, dr, di, tol_w;
        bit      clipped;
        result_t r;
        xr = ar;
        xi = ai;
        yr = br;
        yi = bi;
        tol_w = {97'd0, tol};
        clipped = 1'b0;
        r = '0;
        r.status = ST_OK;
        case (op)
            MODE_ADD: begin
                r.re = clamp_word(xr + yr, clipped);
                r.im = clamp_word(xi + yi, clipped);
            end
            MODE_SUB: begin
                r.re = clamp_word(xr - yr, clipped);
                r.im = clamp_word(xi - yi, clipped);
            end
            MODE_MUL: begin
                part_re = (xr * yr - xi * yi) >>> FRAC_BITS;
                part_im = (xr * yi + xi * yr) >>> FRAC_BITS;
                r.re = clamp_word(part_re, clipped);
                r.im = clamp_word(part_im, clipped);
            end
            MODE_DIV: begin
                mag2 = yr * yr + yi * yi;
                if (mag2 != 0) begin
                    // Signed division in SystemVerilog truncates toward zero.
                    part_re = ((xr * yr + xi * yi) <<< FRAC_BITS) / mag2;
                    part_im = ((xi * yr - xr * yi) <<< FRAC_BITS) / mag2;
                    r.re = clamp_word(part_re, clipped);
                    r.im = clamp_word(part_im, clipped);
                end
            end
            MODE_NEG: begin
                r.re = clamp_word(-xr, clipped);
                r.im = clamp_word(-xi, clipped);
            end
            MODE_EQ: begin
                dr = xr - yr;
                di = xi - yi;
                if (dr < 0) dr = -dr;
                if (di < 0) di = -di;
                r.eq = (dr < tol_w) && (di < tol_w);
            end
            default: ;
        endcase
        if (op == MODE_DIV && yr == 0 && yi == 0) r.status = ST_DIV0;
        else if (clipped) r.status = ST_SAT;
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            tolerance <= TOL_RESET;
            awaited_q.delete();
            mismatches <= 0;
            pending <= 0;
        end else begin
            if (cfg_we) tolerance <= cfg_wdata;
            if (s_valid && s_ready)
                awaited_q.push_back(complex_result(s_mode, s_a_re, s_a_im, s_b_re, s_b_im,
                                                   tolerance));
            if (m_valid && m_ready) begin
                if (awaited_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result item arrived with none outstanding", $time);
                    mismatches <= mismatches + 1;
                end else begin
                    want = awaited_q.pop_front();
                    if (want.re !== m_res_re || want.im !== m_res_im ||
                        want.eq !== m_is_equal || want.status !== m_status) begin
                        if (mismatches < 10)
                            $display("%0t: mismatch re %h/%h im %h/%h eq %b/%b st %0d/%0d",
                                     $time, want.re, m_res_re, want.im, m_res_im,
                                     want.eq, m_is_equal, want.status, m_status);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending <= awaited_q.size();
        end
    end

endmodule

/* tb/complex_arithmetic_unit_top_tb.sv */
`timescale 1ns / 1ps

module complex_arithmetic_unit_top_tb;
    import cau_pkg::*;

    // Drain wait covering the register stages of the block, with margin.
    localparam int DRAIN_CYCLES = DATA_W + 6 + 10;
    localparam int PHASE_ITEMS  = 180;
    localparam logic signed [DATA_W-1:0] VMAX = 32'sh7FFFFFFF;
    localparam logic signed [DATA_W-1:0] VMIN = 32'sh80000000;
    localparam logic signed [DATA_W-1:0] ONE  = 32'sh00010000;
    // The two mode codes that carry no operation.
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [MODE_W-1:0]        s_mode = '0;
    logic signed [DATA_W-1:0] s_a_re = '0;
    logic signed [DATA_W-1:0] s_a_im = '0;
    logic signed [DATA_W-1:0] s_b_re = '0;
    logic signed [DATA_W-1:0] s_b_im = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_res_re;
    logic signed [DATA_W-1:0] m_res_im;
    logic                     m_is_equal;
    logic [STATUS_W-1:0]      m_status;
    logic                     cfg_we = 1'b0;
    logic [TOL_W-1:0]         cfg_wdata = '0;

    int mismatches;
    int pending;

    // Random idling is switched off for one whole phase to get a dense stretch.
    bit idling_on = 1'b1;
    // Raised by the stimulus to make the receiver hold off for a long time.
    bit hold_off_req = 1'b0;
    // Tolerance currently programmed, so equality items can be aimed at its edge.
    logic [TOL_W-1:0] cur_tol = TOL_RESET;

    always #5 aclk = ~aclk;

    complex_arithmetic_unit_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_a_re(s_a_re), .s_a_im(s_a_im), .s_b_re(s_b_re), .s_b_im(s_b_im),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_res_re(m_res_re), .m_res_im(m_res_im),
        .m_is_equal(m_is_equal), .m_status(m_status),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    complex_arithmetic_unit_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_a_re(s_a_re), .s_a_im(s_a_im), .s_b_re(s_b_re), .s_b_im(s_b_im),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_res_re(m_res_re), .m_res_im(m_res_im),
        .m_is_equal(m_is_equal), .m_status(m_status),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .mismatches(mismatches), .pending(pending)
    );

    // The receiver drives m_ready at falling edges. A hold-off request keeps it low
    // for a long counted stretch so the pipeline fills up and backs up the input.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready = 1'b0;
                repeat (300) @(negedge aclk);
                hold_off_req = 1'b0;
            end else begin
                m_ready = aresetn && (!idling_on || $urandom_range(0, 99) >= 10);
            end
        end
    end

    // Offers one item starting at a falling edge and returns at the falling edge after
    // it was accepted. An occasional gap is inserted before the item.
    task automatic offer_item(input logic [MODE_W-1:0] op,
                              input logic signed [DATA_W-1:0] ar,
                              input logic signed [DATA_W-1:0] ai,
                              input logic signed [DATA_W-1:0] br,
                              input logic signed [DATA_W-1:0] bi);
        if (idling_on && $urandom_range(0, 99) < 10) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_mode = op;
        s_a_re = ar;
        s_a_im = ai;
        s_b_re = br;
        s_b_im = bi;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Waits for every outstanding result and for the pipeline to empty, then writes
    // the tolerance register.
    task automatic set_tolerance(input logic [TOL_W-1:0] value);
        s_valid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        cur_tol = value;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Operand mix: full-range words, small values around zero, and the extremes.
    function automatic logic signed [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2, 3: return $signed($urandom_range(0, 32'h000C0000)) - 32'sh00060000;
            4: return $signed($urandom_range(0, 32'h00001000)) - 32'sh00000800;
            default: begin
                case ($urandom_range(0, 3))
                    0: return VMAX;
                    1: return VMIN;
                    2: return '0;
                    default: return -32'sd1;
                endcase
            end
        endcase
    endfunction

    // An offset near the tolerance edge, so that equality goes both ways.
    function automatic logic signed [DATA_W-1:0] near_tol();
        logic signed [DATA_W-1:0] d;
        d = $signed({1'b0, cur_tol}) + $signed($urandom_range(0, 2)) - 32'sd1;
        return $urandom_range(0, 1) ? d : -d;
    endfunction

    task automatic random_item();
        logic [MODE_W-1:0]        op;
        logic signed [DATA_W-1:0] ar, ai, br, bi;
        op = MODE_W'($urandom_range(0, 7));
        ar = pick_operand();
        ai = pick_operand();
        br = pick_operand();
        bi = $urandom_range(0, 7) == 0 ? '0 : pick_operand();
        if (op == MODE_EQ && $urandom_range(0, 2) != 0) begin
            // Aim most equality items at the tolerance boundary.
            br = ar + ($urandom_range(0, 1) ? near_tol() : '0);
            bi = ai + near_tol();
        end else if (op == MODE_DIV && $urandom_range(0, 9) == 0) begin
            br = '0;
            bi = '0;
        end
        offer_item(op, ar, ai, br, bi);
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // Directed items under the reset tolerance of one LSB.
        offer_item(MODE_ADD, ONE, -ONE, 2 * ONE, 3 * ONE);
        offer_item(MODE_ADD, VMAX, VMIN, VMAX, VMIN);
        offer_item(MODE_SUB, VMIN, VMAX, VMAX, VMIN);
        offer_item(MODE_SUB, 32'sd5, -32'sd5, 32'sd5, -32'sd5);
        offer_item(MODE_MUL, 2 * ONE, 3 * ONE, -ONE, 4 * ONE);
        offer_item(MODE_MUL, VMAX, VMIN, VMAX, VMIN);
        offer_item(MODE_MUL, -32'sd1, 32'sd1, 32'sd1, 32'sd1);
        offer_item(MODE_MUL, 3 * ONE, 0, -2 * ONE, 0);
        offer_item(MODE_DIV, 4 * ONE, 2 * ONE, ONE, ONE);
        offer_item(MODE_DIV, ONE, ONE, 0, 0);
        offer_item(MODE_DIV, -ONE, 32'sd7, 3 * ONE, 0);
        offer_item(MODE_DIV, VMAX, VMIN, 32'sd1, 0);
        offer_item(MODE_DIV, VMIN, VMIN, VMIN, VMIN);
        offer_item(MODE_NEG, VMIN, VMAX, 0, 0);
        offer_item(MODE_NEG, ONE, -ONE, VMAX, VMIN);
        offer_item(MODE_EQ, ONE, ONE, ONE, ONE);
        offer_item(MODE_EQ, ONE, ONE, ONE + 1, ONE);
        offer_item(MODE_EQ, VMAX, VMIN, VMIN, VMAX);
        offer_item(MODE_SPARE_A, ONE, ONE, ONE, ONE);
        offer_item(MODE_SPARE_B, VMAX, VMIN, VMAX, VMIN);

        // Tolerance zero: nothing can compare equal.
        set_tolerance('0);
        offer_item(MODE_EQ, ONE, ONE, ONE, ONE);
        repeat (PHASE_ITEMS) random_item();

        // Largest tolerance, and a phase with no idling at all.
        set_tolerance(31'h7FFFFFFF);
        idling_on = 1'b0;
        offer_item(MODE_EQ, VMAX, VMIN, VMIN, VMAX);
        offer_item(MODE_EQ, VMAX, 0, 32'sd0, 0);
        repeat (PHASE_ITEMS) random_item();
        idling_on = 1'b1;

        // One integer unit; the receiver holds off while items keep coming.
        set_tolerance(31'h00010000);
        hold_off_req = 1'b1;
        repeat (PHASE_ITEMS) random_item();

        set_tolerance(TOL_W'($urandom_range(1, 64)));
        repeat (PHASE_ITEMS) random_item();

        set_tolerance(TOL_W'($urandom));
        repeat (PHASE_ITEMS) random_item();

        // Drain, then let the pipeline settle before the verdict.
        s_valid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("complex_arithmetic_unit_top regression: pass");
        end else begin
            $display("complex_arithmetic_unit_top regression: fail");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #5ms;
        $display("complex_arithmetic_unit_top regression: fail");
        $finish;
    end

endmodule
